[design/atc_pkg.sv]
// ----------------------------------------------------------------------------
// atc_pkg
// Shared widths, constants, types and the arctangent table for the
// accelerometer tilt conditioner.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int RAW_W    = 10;   // converter sample and calibration width
    localparam int LIM_W    = 15;   // alarm limit width
    localparam int CFG_W    = 15;   // configuration write data width
    localparam int CFG_IDX_W = 3;   // configuration register index width
    localparam int SUM_W    = 16;   // window sum width
    localparam int G_W      = 16;   // milli-g result width
    localparam int PEAK_W   = 15;   // peak magnitude width
    localparam int FILT_W   = 20;   // filtered milli-g, 4 fraction bits
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;
    localparam int MAG_W    = 32;   // sum of three squared milli-g values
    localparam int YZ_W     = 40;   // fy^2 + fz^2

    // milli-g mapping
    localparam int NUM_W      = 22;         // (avg - low) * 2000, signed
    localparam int QW         = 24;         // signed quotient minus offset
    localparam int MG_SCALE   = 2000;
    localparam int MG_OFFSET  = 1000;
    localparam int MG_SAT     = 32767;

    // shared divider
    localparam int DIV_W      = 21;         // dividend and quotient width
    localparam int DIVR_W     = 10;         // divisor width
    localparam int DIV_BITS   = 3;          // quotient bits per cycle
    localparam int DIV_GROUPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W  = 3;

    // CORDIC
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_SHIFT = 20;       // inputs scaled by 2^20
    localparam int CIN_W        = 21;       // signed input width
    localparam int CXW          = 44;       // internal x/y width
    localparam int CZW          = 24;       // angle accumulator width
    localparam int CSTEP_W      = 5;
    localparam int ANG_W        = 16;       // rounded angle width
    localparam int QUARTER_TURN = 9000 * 256;
    localparam int ROUND_HALF   = 128;
    localparam int ROLL_LIM     = 18000;
    localparam int PITCH_LIM    = 9000;

    // integer square root
    localparam int SQ_TOP_BIT = 38;         // highest even bit below YZ_W

    // job queue
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM  = 3'd6;

    // calibration reset values
    localparam logic [RAW_W-1:0] RST_X_LOW  = 10'd265;
    localparam logic [RAW_W-1:0] RST_X_HIGH = 10'd398;
    localparam logic [RAW_W-1:0] RST_Y_LOW  = 10'd259;
    localparam logic [RAW_W-1:0] RST_Y_HIGH = 10'd393;
    localparam logic [RAW_W-1:0] RST_Z_LOW  = 10'd281;
    localparam logic [RAW_W-1:0] RST_Z_HIGH = 10'd413;
    localparam logic [LIM_W-1:0] RST_ALARM  = 15'd1000;

    // one finished window, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic             clr;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_AVG_START,
        BK_MG_START,
        BK_MG_WAIT,
        BK_AXIS,
        BK_SQ1,
        BK_SQ2,
        BK_ROLL_START,
        BK_ROLL_WAIT,
        BK_PITCH_START,
        BK_PITCH_WAIT,
        BK_DONE
    } back_state_t;

    // atan(2^-i) in 1/256 hundredth-degree units
    function automatic logic signed [CZW-1:0] cordic_atan(input logic [CSTEP_W-1:0] i);
        logic signed [CZW-1:0] v;
        case (i)
            5'd0:    v = 24'sd1152000;
            5'd1:    v = 24'sd680065;
            5'd2:    v = 24'sd359328;
            5'd3:    v = 24'sd182400;
            5'd4:    v = 24'sd91554;
            5'd5:    v = 24'sd45822;
            5'd6:    v = 24'sd22916;
            5'd7:    v = 24'sd11459;
            5'd8:    v = 24'sd5730;
            5'd9:    v = 24'sd2865;
            5'd10:   v = 24'sd1432;
            5'd11:   v = 24'sd716;
            5'd12:   v = 24'sd358;
            5'd13:   v = 24'sd179;
            5'd14:   v = 24'sd90;
            5'd15:   v = 24'sd45;
            5'd16:   v = 24'sd22;
            5'd17:   v = 24'sd11;
            5'd18:   v = 24'sd6;
            5'd19:   v = 24'sd3;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/atc_front.sv]
// ----------------------------------------------------------------------------
// atc_front
// Sample accumulator: sums each axis over a window and pushes one job per
// window into the queue.
// ----------------------------------------------------------------------------
module atc_front #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [atc_pkg::RAW_W-1:0]   s_raw_x,
    input  logic [atc_pkg::RAW_W-1:0]   s_raw_y,
    input  logic [atc_pkg::RAW_W-1:0]   s_raw_z,
    input  logic                        s_clear_peaks,
    input  logic                        q_full,
    output logic                        q_push,
    output atc_pkg::job_t               q_job
);

    localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [atc_pkg::SUM_W-1:0]      sx_reg, sy_reg, sz_reg;
    logic [atc_pkg::SUM_W-1:0]      sx_next, sy_next, sz_next;
    logic                           clr_reg, clr_next;
    logic                           accept;
    logic [atc_pkg::SUM_W-1:0]      ax, ay, az;
    logic                           aclr;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign ax   = sx_reg + atc_pkg::SUM_W'(s_raw_x);
    assign ay   = sy_reg + atc_pkg::SUM_W'(s_raw_y);
    assign az   = sz_reg + atc_pkg::SUM_W'(s_raw_z);
    assign aclr = clr_reg || s_clear_peaks;

    assign q_push      = accept && (cnt_reg == LAST);
    assign q_job.sum_x = ax;
    assign q_job.sum_y = ay;
    assign q_job.sum_z = az;
    assign q_job.clr   = aclr;

    always_comb begin
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sz_next  = sz_reg;
        clr_next = clr_reg;
        if (accept) begin
            if (cnt_reg == LAST) begin
                // window closes: hand it off and start over
                cnt_next = '0;
                sx_next  = '0;
                sy_next  = '0;
                sz_next  = '0;
                clr_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                sx_next  = ax;
                sy_next  = ay;
                sz_next  = az;
                clr_next = aclr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            clr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            clr_reg <= clr_next;
        end
    end

endmodule

[design/atc_fifo.sv]
// ----------------------------------------------------------------------------
// atc_fifo
// Short job queue between the accumulator and the back end.
// ----------------------------------------------------------------------------
module atc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  atc_pkg::job_t   wr_job,
    output logic            full,
    input  logic            pop,
    output atc_pkg::job_t   rd_job,
    output logic            rd_valid
);

    localparam int PTR_W = $clog2(atc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(atc_pkg::QUEUE_DEPTH + 1);

    atc_pkg::job_t      mem [atc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(atc_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(atc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(atc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[design/atc_div.sv]
// ----------------------------------------------------------------------------
// atc_div
// Unsigned restoring divider, a few quotient bits per cycle.
// ----------------------------------------------------------------------------
module atc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [atc_pkg::DIV_W-1:0]   dividend,
    input  logic [atc_pkg::DIVR_W-1:0]  divisor,
    output logic                        done,
    output logic [atc_pkg::DIV_W-1:0]   quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [atc_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [atc_pkg::DIVR_W-1:0]     rem_reg, rem_next;
    logic [atc_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [atc_pkg::DIVR_W-1:0]     dvs_reg;
    logic [atc_pkg::DIVR_W:0]       trial;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // shift dividend bits out the top, quotient bits in at the bottom
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < atc_pkg::DIV_BITS; k++) begin
            trial    = {rem_next, quo_next[atc_pkg::DIV_W-1]};
            quo_next = {quo_next[atc_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[atc_pkg::DIVR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == atc_pkg::DIV_CNT_W'(atc_pkg::DIV_GROUPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

[design/atc_cordic.sv]
// ----------------------------------------------------------------------------
// atc_cordic
// Vectoring CORDIC atan2, one iteration per cycle, angle in hundredths of
// a degree rounded half up.
// ----------------------------------------------------------------------------
module atc_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [atc_pkg::CIN_W-1:0]    y_in,
    input  logic signed [atc_pkg::CIN_W-1:0]    x_in,
    output logic                                done,
    output logic signed [atc_pkg::ANG_W-1:0]    angle
);

    logic                                   busy_reg, done_reg, zero_reg;
    logic [atc_pkg::CSTEP_W-1:0]            step_reg;
    logic signed [atc_pkg::CXW-1:0]         x_reg, y_reg;
    logic signed [atc_pkg::CZW-1:0]         z_reg;
    logic signed [atc_pkg::CXW-1:0]         xs, ys, dx, dy;
    logic signed [atc_pkg::CXW-1:0]         x0, y0;
    logic signed [atc_pkg::CZW-1:0]         z0, zr;

    assign done  = done_reg;
    assign zr    = (z_reg + atc_pkg::CZW'(atc_pkg::ROUND_HALF)) >>> 8;
    assign angle = zero_reg ? '0 : atc_pkg::ANG_W'(zr);

    assign xs = atc_pkg::CXW'(x_in) <<< atc_pkg::CORDIC_SHIFT;
    assign ys = atc_pkg::CXW'(y_in) <<< atc_pkg::CORDIC_SHIFT;
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;

    // pre-rotate the left half-plane by a quarter turn
    always_comb begin
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x0 = ys;
                y0 = -xs;
                z0 = atc_pkg::CZW'(atc_pkg::QUARTER_TURN);
            end else begin
                x0 = -ys;
                y0 = xs;
                z0 = -atc_pkg::CZW'(atc_pkg::QUARTER_TURN);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == atc_pkg::CSTEP_W'(atc_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            zero_reg <= (x_in == '0) && (y_in == '0);
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atc_pkg::cordic_atan(step_reg);
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atc_pkg::cordic_atan(step_reg);
            end
        end
    end

endmodule

[design/atc_back.sv]
// ----------------------------------------------------------------------------
// atc_back
// Window processor: milli-g mapping, peaks, low-pass, square root, roll and
// pitch, alarm, and the result register.
// ----------------------------------------------------------------------------
module atc_back #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    job_valid,
    input  atc_pkg::job_t                           job,
    output logic                                    job_pop,
    input  logic [2:0][atc_pkg::RAW_W-1:0]          cal_low,
    input  logic [2:0][atc_pkg::RAW_W-1:0]          cal_high,
    input  logic [atc_pkg::LIM_W-1:0]               alarm_limit,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [atc_pkg::G_W-1:0]          m_g_x,
    output logic signed [atc_pkg::G_W-1:0]          m_g_y,
    output logic signed [atc_pkg::G_W-1:0]          m_g_z,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_x,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_y,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_z,
    output logic signed [atc_pkg::ROLL_W-1:0]       m_roll,
    output logic signed [atc_pkg::PITCH_W-1:0]      m_pitch,
    output logic                                    m_alarm
);

    localparam int FS_W = atc_pkg::FILT_W + 1;

    // window average by reciprocal multiply, exact for any 16-bit sum
    localparam int RCP_SH = atc_pkg::SUM_W + $clog2(SAMPLES_PER_RESULT);
    localparam int RCP_W  = atc_pkg::SUM_W + 1;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(SAMPLES_PER_RESULT) - 64'd1) /
               64'(SAMPLES_PER_RESULT));

    atc_pkg::back_state_t state_reg, state_next;

    // working state
    logic [1:0]                                 axis_reg;
    logic [2:0][atc_pkg::SUM_W-1:0]             sum_reg;
    logic [atc_pkg::RAW_W-1:0]                  avg_reg;
    logic                                       neg_reg;
    logic signed [atc_pkg::G_W-1:0]             g_cur_reg;
    logic [2:0][atc_pkg::G_W-1:0]               g_reg;
    logic [2:0][atc_pkg::PEAK_W-1:0]            peak_reg;
    logic [2:0][atc_pkg::FILT_W-1:0]            filt_reg;
    logic [atc_pkg::MAG_W-1:0]                  mag2_reg;
    logic [atc_pkg::YZ_W-1:0]                   yz_reg;
    logic signed [atc_pkg::ANG_W-1:0]           roll_reg;
    logic                                       roll_got_reg;
    logic [atc_pkg::YZ_W-1:0]                   sq_v_reg, sq_r_reg, sq_bit_reg;

    // result register
    logic                                       m_valid_reg;
    logic [2:0][atc_pkg::G_W-1:0]               o_g_reg;
    logic [2:0][atc_pkg::PEAK_W-1:0]            o_peak_reg;
    logic signed [atc_pkg::ROLL_W-1:0]          o_roll_reg;
    logic signed [atc_pkg::PITCH_W-1:0]         o_pitch_reg;
    logic                                       o_alarm_reg;

    // control
    logic                                       div_start, cd_start, out_load;
    logic                                       div_done, cd_done;
    logic [atc_pkg::DIV_W-1:0]                  div_dividend, div_quot;
    logic [atc_pkg::DIVR_W-1:0]                 div_divisor;
    logic signed [atc_pkg::CIN_W-1:0]           cd_y, cd_x;
    logic signed [atc_pkg::ANG_W-1:0]           cd_angle;

    // datapath
    logic [atc_pkg::SUM_W+RCP_W-1:0]            avg_prod;
    logic [atc_pkg::RAW_W-1:0]                  low_sel, high_sel;
    logic signed [atc_pkg::RAW_W:0]             diff_w, span_w;
    logic signed [atc_pkg::NUM_W-1:0]           num_w;
    logic [atc_pkg::DIV_W-1:0]                  num_abs;
    logic [atc_pkg::RAW_W-1:0]                  span_abs;
    logic                                       span_zero;
    logic signed [atc_pkg::QW-1:0]              q_mag, q_sgn, q_off;
    logic signed [atc_pkg::G_W-1:0]             g_sat;
    logic [atc_pkg::PEAK_W-1:0]                 g_abs;
    logic signed [FS_W-1:0]                     filt_sum;
    logic signed [2*atc_pkg::G_W-1:0]           g_sq;
    logic signed [atc_pkg::FILT_W-1:0]          sq_in;
    logic signed [2*atc_pkg::FILT_W-1:0]        f_sq;
    logic [atc_pkg::YZ_W-1:0]                   sq_sum;
    logic signed [atc_pkg::ROLL_W-1:0]          roll_cl;
    logic signed [atc_pkg::ANG_W-1:0]           pitch_cl;
    logic [2*atc_pkg::LIM_W-1:0]                lim_sq;

    atc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    atc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .y_in    (cd_y),
        .x_in    (cd_x),
        .done    (cd_done),
        .angle   (cd_angle)
    );

    // ---------------- window average ----------------
    assign avg_prod = sum_reg[axis_reg] * RCP_MUL;

    // ---------------- milli-g mapping ----------------
    assign low_sel   = cal_low[axis_reg];
    assign high_sel  = cal_high[axis_reg];
    assign diff_w    = $signed({1'b0, avg_reg}) - $signed({1'b0, low_sel});
    assign span_w    = $signed({1'b0, high_sel}) - $signed({1'b0, low_sel});
    assign span_zero = (span_w == '0);
    assign num_w     = atc_pkg::NUM_W'(diff_w) * atc_pkg::NUM_W'(atc_pkg::MG_SCALE);
    assign num_abs   = num_w[atc_pkg::NUM_W-1] ? atc_pkg::DIV_W'(-num_w) :
                                                 atc_pkg::DIV_W'(num_w);
    assign span_abs  = span_w[atc_pkg::RAW_W] ? atc_pkg::RAW_W'(-span_w) :
                                                atc_pkg::RAW_W'(span_w);

    // quotient truncates toward zero, then offset and saturate
    assign q_mag = $signed(atc_pkg::QW'(div_quot));
    assign q_sgn = neg_reg ? -q_mag : q_mag;
    assign q_off = q_sgn - atc_pkg::QW'(atc_pkg::MG_OFFSET);

    always_comb begin
        if (q_off > atc_pkg::QW'(atc_pkg::MG_SAT)) begin
            g_sat = atc_pkg::G_W'(atc_pkg::MG_SAT);
        end else if (q_off < -atc_pkg::QW'(atc_pkg::MG_SAT)) begin
            g_sat = -atc_pkg::G_W'(atc_pkg::MG_SAT);
        end else begin
            g_sat = atc_pkg::G_W'(q_off);
        end
    end

    // ---------------- per-axis update ----------------
    assign g_abs    = g_cur_reg[atc_pkg::G_W-1] ? atc_pkg::PEAK_W'(-g_cur_reg) :
                                                  atc_pkg::PEAK_W'(g_cur_reg);
    assign filt_sum = FS_W'($signed({g_cur_reg, 4'b0000}))
                    + FS_W'($signed(filt_reg[axis_reg]));
    assign g_sq     = g_cur_reg * g_cur_reg;

    // ---------------- fy^2 + fz^2 ----------------
    assign sq_in = (state_reg == atc_pkg::BK_SQ1) ? $signed(filt_reg[1]) :
                                                    $signed(filt_reg[2]);
    assign f_sq  = sq_in * sq_in;
    assign sq_sum = sq_r_reg + sq_bit_reg;

    // ---------------- angles and alarm ----------------
    always_comb begin
        if (roll_reg > atc_pkg::ANG_W'(atc_pkg::ROLL_LIM)) begin
            roll_cl = atc_pkg::ROLL_W'(atc_pkg::ROLL_LIM);
        end else if (roll_reg < -atc_pkg::ANG_W'(atc_pkg::ROLL_LIM)) begin
            roll_cl = -atc_pkg::ROLL_W'(atc_pkg::ROLL_LIM);
        end else begin
            roll_cl = roll_reg;
        end
        if (cd_angle > atc_pkg::ANG_W'(atc_pkg::PITCH_LIM)) begin
            pitch_cl = atc_pkg::ANG_W'(atc_pkg::PITCH_LIM);
        end else if (cd_angle < -atc_pkg::ANG_W'(atc_pkg::PITCH_LIM)) begin
            pitch_cl = -atc_pkg::ANG_W'(atc_pkg::PITCH_LIM);
        end else begin
            pitch_cl = cd_angle;
        end
    end

    assign lim_sq = alarm_limit * alarm_limit;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            atc_pkg::BK_IDLE: begin
                if (job_valid) begin
                    state_next = atc_pkg::BK_AVG_START;
                end
            end
            atc_pkg::BK_AVG_START: state_next = atc_pkg::BK_MG_START;
            atc_pkg::BK_MG_START: begin
                state_next = span_zero ? atc_pkg::BK_AXIS : atc_pkg::BK_MG_WAIT;
            end
            atc_pkg::BK_MG_WAIT: begin
                if (div_done) begin
                    state_next = atc_pkg::BK_AXIS;
                end
            end
            atc_pkg::BK_AXIS: begin
                state_next = (axis_reg == 2'd2) ? atc_pkg::BK_SQ1 : atc_pkg::BK_AVG_START;
            end
            atc_pkg::BK_SQ1:        state_next = atc_pkg::BK_SQ2;
            atc_pkg::BK_SQ2:        state_next = atc_pkg::BK_ROLL_START;
            atc_pkg::BK_ROLL_START: state_next = atc_pkg::BK_ROLL_WAIT;
            atc_pkg::BK_ROLL_WAIT: begin
                if (roll_got_reg && (sq_bit_reg == '0)) begin
                    state_next = atc_pkg::BK_PITCH_START;
                end
            end
            atc_pkg::BK_PITCH_START: state_next = atc_pkg::BK_PITCH_WAIT;
            atc_pkg::BK_PITCH_WAIT: begin
                if (cd_done) begin
                    state_next = atc_pkg::BK_DONE;
                end
            end
            atc_pkg::BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = atc_pkg::BK_IDLE;
                end
            end
            default: state_next = atc_pkg::BK_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        job_pop      = 1'b0;
        div_start    = 1'b0;
        cd_start     = 1'b0;
        out_load     = 1'b0;
        div_dividend = num_abs;
        div_divisor  = span_abs;
        cd_y         = -atc_pkg::CIN_W'($signed(filt_reg[1]));
        cd_x         = atc_pkg::CIN_W'($signed(filt_reg[2]));
        case (state_reg)
            atc_pkg::BK_IDLE: job_pop = job_valid;
            atc_pkg::BK_MG_START:   div_start = !span_zero;
            atc_pkg::BK_ROLL_START: cd_start = 1'b1;
            atc_pkg::BK_PITCH_START: begin
                cd_start = 1'b1;
                cd_y     = atc_pkg::CIN_W'($signed(filt_reg[0]));
                cd_x     = $signed(atc_pkg::CIN_W'(sq_r_reg));
            end
            atc_pkg::BK_DONE: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= atc_pkg::BK_IDLE;
            m_valid_reg  <= 1'b0;
            peak_reg     <= '0;
            filt_reg     <= '0;
            sq_bit_reg   <= '0;
            roll_got_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (job_pop && job.clr) begin
                peak_reg <= '0;
            end else if (state_reg == atc_pkg::BK_AXIS) begin
                if (g_abs > peak_reg[axis_reg]) begin
                    peak_reg[axis_reg] <= g_abs;
                end
                filt_reg[axis_reg] <= filt_sum[FS_W-1:1];
            end
            if (state_reg == atc_pkg::BK_ROLL_START) begin
                sq_bit_reg   <= atc_pkg::YZ_W'(1) << atc_pkg::SQ_TOP_BIT;
                roll_got_reg <= 1'b0;
            end else begin
                if (sq_bit_reg != '0) begin
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                if ((state_reg == atc_pkg::BK_ROLL_WAIT) && cd_done) begin
                    roll_got_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            sum_reg  <= {job.sum_z, job.sum_y, job.sum_x};
            axis_reg <= 2'd0;
            mag2_reg <= '0;
        end
        if (state_reg == atc_pkg::BK_AVG_START) begin
            avg_reg <= avg_prod[RCP_SH +: atc_pkg::RAW_W];
        end
        if (state_reg == atc_pkg::BK_MG_START) begin
            neg_reg <= num_w[atc_pkg::NUM_W-1] ^ span_w[atc_pkg::RAW_W];
            if (span_zero) begin
                g_cur_reg <= '0;
            end
        end
        if ((state_reg == atc_pkg::BK_MG_WAIT) && div_done) begin
            g_cur_reg <= g_sat;
        end
        if (state_reg == atc_pkg::BK_AXIS) begin
            g_reg[axis_reg] <= g_cur_reg;
            mag2_reg        <= mag2_reg + atc_pkg::MAG_W'(g_sq);
            axis_reg        <= axis_reg + 1'b1;
        end
        if (state_reg == atc_pkg::BK_SQ1) begin
            yz_reg <= atc_pkg::YZ_W'(f_sq);
        end else if (state_reg == atc_pkg::BK_SQ2) begin
            yz_reg <= yz_reg + atc_pkg::YZ_W'(f_sq);
        end
        // integer square root, one result bit per cycle
        if (state_reg == atc_pkg::BK_ROLL_START) begin
            sq_v_reg <= yz_reg;
            sq_r_reg <= '0;
        end else if (sq_bit_reg != '0) begin
            if (sq_v_reg >= sq_sum) begin
                sq_v_reg <= sq_v_reg - sq_sum;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
        end
        if ((state_reg == atc_pkg::BK_ROLL_WAIT) && cd_done) begin
            roll_reg <= cd_angle;
        end
        if (out_load) begin
            o_g_reg     <= g_reg;
            o_peak_reg  <= peak_reg;
            o_roll_reg  <= roll_cl;
            o_pitch_reg <= atc_pkg::PITCH_W'(pitch_cl);
            o_alarm_reg <= (mag2_reg > atc_pkg::MAG_W'(lim_sq));
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_g_x    = o_g_reg[0];
    assign m_g_y    = o_g_reg[1];
    assign m_g_z    = o_g_reg[2];
    assign m_peak_x = o_peak_reg[0];
    assign m_peak_y = o_peak_reg[1];
    assign m_peak_z = o_peak_reg[2];
    assign m_roll   = o_roll_reg;
    assign m_pitch  = o_pitch_reg;
    assign m_alarm  = o_alarm_reg;

endmodule

[design/accel_tilt_conditioner_core.sv]
// ----------------------------------------------------------------------------
// accel_tilt_conditioner_core
// Accelerometer conditioner: window average, milli-g calibration, peaks,
// low-pass, roll/pitch by CORDIC and a magnitude alarm.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  -------   ---------  -----------------------------------------------------
//  s_*       in         raw_x, raw_y, raw_z samples and clear_peaks
//  m_*       out        g_x/y/z, peak_x/y/z, roll, pitch, alarm (one per window)
//  cfg_*     in         register index and write data (calibration, alarm limit)
//
//  Cycles: one sample beat is taken per cycle while the job queue has room.
//  The back end works through a window in order: per axis the average
//  (reciprocal multiply), a divider pass (skipped for a zero span) and
//  an update, then the squares of filtered y and z, the roll CORDIC
//  (20 iterations, square root running beside it) and the pitch CORDIC
//  (20 iterations). The shared CORDIC unit and divider set its pace.
//  Reset: aresetn, synchronous, active low; clears the window, filter, peaks,
//  queue and calibration registers to their defaults.
//  Stalls: a waiting result holds in the output register; the queue lets the
//  front keep taking samples until two windows are waiting.
//
module accel_tilt_conditioner_core #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [atc_pkg::RAW_W-1:0]               s_raw_x,
    input  logic [atc_pkg::RAW_W-1:0]               s_raw_y,
    input  logic [atc_pkg::RAW_W-1:0]               s_raw_z,
    input  logic                                    s_clear_peaks,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [atc_pkg::G_W-1:0]          m_g_x,
    output logic signed [atc_pkg::G_W-1:0]          m_g_y,
    output logic signed [atc_pkg::G_W-1:0]          m_g_z,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_x,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_y,
    output logic [atc_pkg::PEAK_W-1:0]              m_peak_z,
    output logic signed [atc_pkg::ROLL_W-1:0]       m_roll,
    output logic signed [atc_pkg::PITCH_W-1:0]      m_pitch,
    output logic                                    m_alarm,
    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [atc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [atc_pkg::CFG_W-1:0]               cfg_data
);

    // calibration and alarm limit registers
    logic [2:0][atc_pkg::RAW_W-1:0] cal_low_reg, cal_high_reg;
    logic [atc_pkg::LIM_W-1:0]      alarm_limit_reg;

    // front to queue to back
    logic           q_push, q_full, q_pop, q_valid;
    atc_pkg::job_t  q_wr_job, q_rd_job;

    // always take config beats; indexes past the list drop silently
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_low_reg[0]  <= atc_pkg::RST_X_LOW;
            cal_high_reg[0] <= atc_pkg::RST_X_HIGH;
            cal_low_reg[1]  <= atc_pkg::RST_Y_LOW;
            cal_high_reg[1] <= atc_pkg::RST_Y_HIGH;
            cal_low_reg[2]  <= atc_pkg::RST_Z_LOW;
            cal_high_reg[2] <= atc_pkg::RST_Z_HIGH;
            alarm_limit_reg <= atc_pkg::RST_ALARM;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                atc_pkg::CFG_X_LOW:  cal_low_reg[0]  <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_X_HIGH: cal_high_reg[0] <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_Y_LOW:  cal_low_reg[1]  <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_Y_HIGH: cal_high_reg[1] <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_Z_LOW:  cal_low_reg[2]  <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_Z_HIGH: cal_high_reg[2] <= cfg_data[atc_pkg::RAW_W-1:0];
                atc_pkg::CFG_ALARM:  alarm_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // accumulate samples; one job per finished window
    atc_front #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_x       (s_raw_x),
        .s_raw_y       (s_raw_y),
        .s_raw_z       (s_raw_z),
        .s_clear_peaks (s_clear_peaks),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_wr_job)
    );

    // decouple the sample side from the slow window math
    atc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_job   (q_wr_job),
        .full     (q_full),
        .pop      (q_pop),
        .rd_job   (q_rd_job),
        .rd_valid (q_valid)
    );

    // window math and result register
    atc_back #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_valid),
        .job         (q_rd_job),
        .job_pop     (q_pop),
        .cal_low     (cal_low_reg),
        .cal_high    (cal_high_reg),
        .alarm_limit (alarm_limit_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_g_x       (m_g_x),
        .m_g_y       (m_g_y),
        .m_g_z       (m_g_z),
        .m_peak_x    (m_peak_x),
        .m_peak_y    (m_peak_y),
        .m_peak_z    (m_peak_z),
        .m_roll      (m_roll),
        .m_pitch     (m_pitch),
        .m_alarm     (m_alarm)
    );

endmodule

[sim/tb_accel_tilt_conditioner_core.sv]
// ----------------------------------------------------------------------------
// tb_accel_tilt_conditioner_core
// Self-checking bench for the accelerometer tilt conditioner: a directed
// table of sample beats, then randomized windows under several calibration
// settings, every result compared field by field against a local predictor
// of the window average, milli-g mapping, peaks, low-pass, CORDIC tilt and
// magnitude alarm.
// ----------------------------------------------------------------------------
module tb_accel_tilt_conditioner_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = 10;
    localparam int SETTLE_CYC   = 250;   // time for the back end to go quiet after draining
    localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int PHASE_ITEMS  = 118;
    localparam logic [atc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // one expected result beat
    typedef struct {
        logic signed [atc_pkg::G_W-1:0]     gx, gy, gz;
        logic [atc_pkg::PEAK_W-1:0]         px, py, pz;
        logic signed [atc_pkg::ROLL_W-1:0]  roll;
        logic signed [atc_pkg::PITCH_W-1:0] pitch;
        logic                               alarm;
    } tilt_result_t;

    // directed stimulus row; fixed_mg marks rows whose milli-g values are known
    typedef struct {
        int raw_x, raw_y, raw_z;
        bit clr;
        bit fixed_mg;
        int mg;
    } sample_row_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [atc_pkg::RAW_W-1:0]            s_raw_x, s_raw_y, s_raw_z;
    logic                                 s_clear_peaks;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [atc_pkg::G_W-1:0]       m_g_x, m_g_y, m_g_z;
    logic [atc_pkg::PEAK_W-1:0]           m_peak_x, m_peak_y, m_peak_z;
    logic signed [atc_pkg::ROLL_W-1:0]    m_roll;
    logic signed [atc_pkg::PITCH_W-1:0]   m_pitch;
    logic                                 m_alarm;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [atc_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [atc_pkg::CFG_W-1:0]            cfg_data;

    accel_tilt_conditioner_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_raw_x(s_raw_x), .s_raw_y(s_raw_y), .s_raw_z(s_raw_z),
        .s_clear_peaks(s_clear_peaks),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_g_x(m_g_x), .m_g_y(m_g_y), .m_g_z(m_g_z),
        .m_peak_x(m_peak_x), .m_peak_y(m_peak_y), .m_peak_z(m_peak_z),
        .m_roll(m_roll), .m_pitch(m_pitch), .m_alarm(m_alarm),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: calibration, window sums, filter and peaks
    // ------------------------------------------------------------------
    int                       cal_lo[3];
    int                       cal_hi[3];
    longint                   limit_mg;
    int                       win_count;
    bit [atc_pkg::SUM_W-1:0]  win_sum[3];
    int                       filt_mg[3];
    int                       peak_mg[3];

    tilt_result_t    pending_results[$];
    int              errors;
    int              hold_req;       // long receiver hold-off, in cycles
    int              idle_cycles;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // count cycles in which no beat moves on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic of the block
    // ------------------------------------------------------------------
    function automatic int raw_to_mg(int avg, int lo, int hi);
        int span;
        int q;
        span = hi - lo;
        if (span == 0) return 0;
        // truncates toward zero
        q = ((avg - lo) * atc_pkg::MG_SCALE) / span - atc_pkg::MG_OFFSET;
        if (q > atc_pkg::MG_SAT) q = atc_pkg::MG_SAT;
        if (q < -atc_pkg::MG_SAT) q = -atc_pkg::MG_SAT;
        return q;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // atan2(num, den) in hundredths of a degree, vectoring CORDIC
    function automatic int tilt_angle(longint num, longint den);
        longint ax, ay, az, t, dx, dy;
        longint step_ang[atc_pkg::CORDIC_STEPS] = '{1152000, 680065, 359328, 182400,
            91554, 45822, 22916, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22,
            11, 6, 3};
        if (num == 0 && den == 0) return 0;
        ax = den <<< atc_pkg::CORDIC_SHIFT;
        ay = num <<< atc_pkg::CORDIC_SHIFT;
        az = 0;
        // fold the left half plane onto the right one
        if (ax < 0) begin
            if (ay >= 0) begin
                t = ax; ax = ay; ay = -t; az = atc_pkg::QUARTER_TURN;
            end else begin
                t = ax; ax = -ay; ay = t; az = -atc_pkg::QUARTER_TURN;
            end
        end
        for (int i = 0; i < atc_pkg::CORDIC_STEPS; i++) begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (ay > 0) begin
                ax += dx; ay -= dy; az += step_ang[i];
            end else begin
                ax -= dx; ay += dy; az -= step_ang[i];
            end
        end
        return int'((az + atc_pkg::ROUND_HALF) >>> 8);
    endfunction

    function automatic int clamp_lim(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // advance the window by one accepted sample; push a result at window end
    function automatic void predict_sample(int rx, int ry, int rz, bit clr,
                                           bit fixed_mg, int mg);
        int raw[3];
        int g[3];
        int mabs;
        longint mag2;
        longint yz;
        tilt_result_t r;
        raw[0] = rx; raw[1] = ry; raw[2] = rz;
        if (clr) begin
            peak_mg[0] = 0; peak_mg[1] = 0; peak_mg[2] = 0;
        end
        for (int a = 0; a < 3; a++)
            win_sum[a] = win_sum[a] + raw[a][atc_pkg::RAW_W-1:0];
        win_count++;
        if (win_count < WINDOW) return;

        mag2 = 0;
        for (int a = 0; a < 3; a++) begin
            g[a] = raw_to_mg(int'(win_sum[a]) / WINDOW, cal_lo[a], cal_hi[a]);
            mabs = (g[a] < 0) ? -g[a] : g[a];
            if (mabs > peak_mg[a]) peak_mg[a] = mabs;
            filt_mg[a] = (g[a] * 16 + filt_mg[a]) >>> 1;
            mag2 += longint'(g[a]) * g[a];
            win_sum[a] = '0;
        end
        win_count = 0;

        yz = longint'(filt_mg[1]) * filt_mg[1] + longint'(filt_mg[2]) * filt_mg[2];
        r.gx    = atc_pkg::G_W'(g[0]);
        r.gy    = atc_pkg::G_W'(g[1]);
        r.gz    = atc_pkg::G_W'(g[2]);
        r.px    = atc_pkg::PEAK_W'(peak_mg[0]);
        r.py    = atc_pkg::PEAK_W'(peak_mg[1]);
        r.pz    = atc_pkg::PEAK_W'(peak_mg[2]);
        r.roll  = atc_pkg::ROLL_W'(clamp_lim(tilt_angle(-longint'(filt_mg[1]), filt_mg[2]),
                                             atc_pkg::ROLL_LIM));
        r.pitch = atc_pkg::PITCH_W'(clamp_lim(tilt_angle(filt_mg[0], floor_sqrt(yz)),
                                              atc_pkg::PITCH_LIM));
        r.alarm = (mag2 > limit_mg * limit_mg);
        // rows with an obvious answer carry it in the table
        if (fixed_mg) begin
            r.gx = atc_pkg::G_W'(mg); r.gy = atc_pkg::G_W'(mg); r.gz = atc_pkg::G_W'(mg);
        end
        pending_results.push_back(r);
    endfunction

    function automatic void predict_reg(logic [atc_pkg::CFG_IDX_W-1:0] idx,
                                        logic [atc_pkg::CFG_W-1:0] d);
        case (idx)
            atc_pkg::CFG_X_LOW:  cal_lo[0] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_X_HIGH: cal_hi[0] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_Y_LOW:  cal_lo[1] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_Y_HIGH: cal_hi[1] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_Z_LOW:  cal_lo[2] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_Z_HIGH: cal_hi[2] = int'(d[atc_pkg::RAW_W-1:0]);
            atc_pkg::CFG_ALARM:  limit_mg  = longint'(d[atc_pkg::LIM_W-1:0]);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: compare each beat with the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tilt_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got g_x %0d",
                         $realtime, m_g_x);
                errors++;
            end else begin
                e = pending_results.pop_front();
                compare_field("g_x", e.gx, m_g_x);
                compare_field("g_y", e.gy, m_g_y);
                compare_field("g_z", e.gz, m_g_z);
                compare_field("peak_x", e.px, m_peak_x);
                compare_field("peak_y", e.py, m_peak_y);
                compare_field("peak_z", e.pz, m_peak_z);
                compare_field("roll", e.roll, m_roll);
                compare_field("pitch", e.pitch, m_pitch);
                compare_field("alarm", e.alarm, m_alarm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int left;
        m_ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold_req > 0) begin
                hold_req--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    0:       m_ready = 1'b1;                          // no stalls
                    1:       m_ready = ($urandom_range(0, 1) == 1);
                    2:       m_ready = ($urandom_range(0, 7) == 0);   // mostly stalled
                    default: m_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of beats with random gaps
    // ------------------------------------------------------------------
    int burst_left;

    task automatic send_sample(int rx, int ry, int rz, bit clr, bit fixed_mg, int mg);
        int gap;
        @(negedge aclk);
        s_valid       = 1'b1;
        s_raw_x       = atc_pkg::RAW_W'(rx);
        s_raw_y       = atc_pkg::RAW_W'(ry);
        s_raw_z       = atc_pkg::RAW_W'(rz);
        s_clear_peaks = clr;
        // hold the beat until it is taken
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(rx, ry, rz, clr, fixed_mg, mg);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(0, 30);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic write_reg(logic [atc_pkg::CFG_IDX_W-1:0] idx,
                             logic [atc_pkg::CFG_W-1:0] d);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        predict_reg(idx, d);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drain every expected result, then give the back end time to go quiet
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_cal(int xl, int xh, int yl, int yh, int zl, int zh, int lim);
        wait_drained();
        write_reg(atc_pkg::CFG_X_LOW,  atc_pkg::CFG_W'(xl));
        write_reg(atc_pkg::CFG_X_HIGH, atc_pkg::CFG_W'(xh));
        write_reg(atc_pkg::CFG_Y_LOW,  atc_pkg::CFG_W'(yl));
        write_reg(atc_pkg::CFG_Y_HIGH, atc_pkg::CFG_W'(yh));
        write_reg(atc_pkg::CFG_Z_LOW,  atc_pkg::CFG_W'(zl));
        write_reg(atc_pkg::CFG_Z_HIGH, atc_pkg::CFG_W'(zh));
        write_reg(atc_pkg::CFG_ALARM,  atc_pkg::CFG_W'(lim));
        // index past the last register: must be dropped
        write_reg(CFG_UNUSED, atc_pkg::CFG_W'($urandom_range(0, 32767)));
    endtask

    // random sample: mostly inside the calibrated span, sometimes anywhere
    function automatic int pick_raw(int a);
        int lo;
        int hi;
        lo = (cal_lo[a] < cal_hi[a]) ? cal_lo[a] : cal_hi[a];
        hi = (cal_lo[a] < cal_hi[a]) ? cal_hi[a] : cal_lo[a];
        if ($urandom_range(0, 9) < 7) return $urandom_range(hi, lo);
        return $urandom_range(0, 1023);
    endfunction

    // ------------------------------------------------------------------
    // Directed table: two known windows at reset calibration, then extremes
    // ------------------------------------------------------------------
    sample_row_t directed_rows[25];

    initial begin
        for (int i = 0; i < 10; i++)
            directed_rows[i] = '{265, 259, 281, 1'b0, i == 9, -1000};  // minus one g
        for (int i = 10; i < 20; i++)
            directed_rows[i] = '{398, 393, 413, 1'b0, i == 19, 1000};  // plus one g
        directed_rows[20] = '{0,    0,    0,    1'b1, 1'b0, 0};
        directed_rows[21] = '{1023, 1023, 1023, 1'b0, 1'b0, 0};
        directed_rows[22] = '{1023, 0,    682,  1'b1, 1'b0, 0};
        directed_rows[23] = '{341,  1023, 0,    1'b0, 1'b0, 0};
        directed_rows[24] = '{0,    1023, 1023, 1'b0, 1'b0, 0};
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int kind;
        errors        = 0;
        hold_req      = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_raw_x       = '0;
        s_raw_y       = '0;
        s_raw_z       = '0;
        s_clear_peaks = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;

        cal_lo[0] = 265; cal_hi[0] = 398;
        cal_lo[1] = 259; cal_hi[1] = 393;
        cal_lo[2] = 281; cal_hi[2] = 413;
        limit_mg  = 1000;
        win_count = 0;
        for (int a = 0; a < 3; a++) begin
            win_sum[a] = '0; filt_mg[a] = 0; peak_mg[a] = 0;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].raw_x, directed_rows[i].raw_y,
                        directed_rows[i].raw_z, directed_rows[i].clr,
                        directed_rows[i].fixed_mg, directed_rows[i].mg);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_cal(265, 398, 259, 393, 281, 413, 1000);     // reset values
                1: write_cal(0, 0, 0, 0, 0, 0, 0);                    // zero spans
                2: write_cal(0, 1, 0, 1, 0, 1, 32767);                // saturate high
                3: write_cal(1023, 0, 1023, 0, 1023, 1022, 0);        // reversed spans
                4: write_cal(265, 398, 500, 500, 281, 413, 1500);     // y flat: roll at +-180
                default: write_cal($urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 32767));
            endcase
            // hold the receiver off so the queue fills and the input stalls
            if (ph == 2) hold_req = 600;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 15);
                send_sample(pick_raw(0), pick_raw(1), pick_raw(2),
                            kind == 0, 1'b0, 0);
            end
        end

        wait_drained();
        if (pending_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
